// ----- design/ipf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_pkg: shared types and constants of the IPv4 port filter
// Field widths, protocol constants, verdict codes and the token that travels
// down the row of port table cells.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int PORT_TABLE_DEPTH = 128;
  localparam int CELL_IDX_W = (PORT_TABLE_DEPTH > 1) ? $clog2(PORT_TABLE_DEPTH) : 1;

  localparam int SLOT_IDX_W  = 7;
  localparam int PORT_W      = 16;
  localparam int ADDR_W      = 32;
  localparam int REASON_W    = 4;
  localparam int LEN_W       = 17;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_RESOLVER_ADDR   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESOLVER_ENABLE = 1'b1;

  // Input item kinds carried on tuser.
  localparam logic OP_PACKET_BYTE = 1'b0;
  localparam logic OP_SLOT_WRITE  = 1'b1;

  // Verdict reason codes.
  localparam logic [REASON_W-1:0] REASON_ALLOW     = 4'd0;
  localparam logic [REASON_W-1:0] REASON_TRUNCATED = 4'd1;
  localparam logic [REASON_W-1:0] REASON_NOT_IPV4  = 4'd2;
  localparam logic [REASON_W-1:0] REASON_BAD_IHL   = 4'd3;
  localparam logic [REASON_W-1:0] REASON_TCP_DENY  = 4'd4;
  localparam logic [REASON_W-1:0] REASON_UDP_DENY  = 4'd5;
  localparam logic [REASON_W-1:0] REASON_ICMP_DENY = 4'd6;
  localparam logic [REASON_W-1:0] REASON_IPV6_IN4  = 4'd7;
  localparam logic [REASON_W-1:0] REASON_OTHER     = 4'd8;

  // Header constants.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  PROTO_IPV6     = 8'd41;
  localparam logic [PORT_W-1:0] PORT_HTTPS = 16'd443;
  localparam logic [PORT_W-1:0] PORT_DNS   = 16'd53;
  localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
  localparam logic [3:0]  IHL_MIN        = 4'd5;

  localparam logic [7:0]       ETH_LEN      = 8'd14;
  localparam logic [LEN_W-1:0] IPV4_MIN_LEN = 17'd20;
  localparam logic [LEN_W-1:0] TCP_HDR_LEN  = 17'd20;
  localparam logic [LEN_W-1:0] UDP_HDR_LEN  = 17'd8;
  localparam logic [LEN_W-1:0] ICMP_HDR_LEN = 17'd8;

  // One stage of the cell row: either a slot write, a frame verdict (flagged by
  // lookup when it waits for the port search), or nothing.
  typedef struct packed {
    logic                  query;
    logic                  write;
    logic [SLOT_IDX_W-1:0] idx;
    logic [PORT_W-1:0]     port;
    logic                  slot_on;
    logic [REASON_W-1:0]   reason;
    logic                  lookup;
    logic                  hit;
  } ipf_tok_t;

endpackage

// ----- design/ipf_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_parser: frame header capture and verdict
// Captures header fields byte by byte and, on the last byte, issues a verdict
// token; slot writes become write tokens for the cell row.
// ----------------------------------------------------------------------------
module ipf_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          accept,
  input  logic                          op,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  input  logic [ipf_pkg::SLOT_IDX_W-1:0] slot_index,
  input  logic [ipf_pkg::PORT_W-1:0]    slot_port,
  input  logic                          slot_valid,
  input  logic [ipf_pkg::ADDR_W-1:0]    resolver_addr,
  input  logic                          resolver_enable,
  output ipf_pkg::ipf_tok_t             tok
);
  import ipf_pkg::*;

  logic [15:0]       byte_count;
  logic [15:0]       ether_type, ether_type_next;
  logic [3:0]        header_words, header_words_next;
  logic [7:0]        ip_protocol, ip_protocol_next;
  logic [ADDR_W-1:0] dest_addr, dest_addr_next;
  logic [PORT_W-1:0] l4_dport, l4_dport_next;
  logic [7:0]        icmp_kind, icmp_kind_next;
  logic [7:0]        l4_cur, l4_dec;
  logic [LEN_W-1:0]  len, l4_len;
  logic [REASON_W-1:0] reason;
  logic              lookup;
  ipf_tok_t          tok_next;

  // Field capture at fixed offsets; layer-4 offsets follow the IHL already held.
  always_comb begin
    ether_type_next   = ether_type;
    header_words_next = header_words;
    ip_protocol_next  = ip_protocol;
    dest_addr_next    = dest_addr;
    l4_dport_next     = l4_dport;
    icmp_kind_next    = icmp_kind;
    l4_cur = ETH_LEN + {2'b00, header_words, 2'b00};
    if (byte_count == 16'd12) ether_type_next[15:8] = data_byte;
    if (byte_count == 16'd13) ether_type_next[7:0]  = data_byte;
    if (byte_count == 16'd14) header_words_next     = data_byte[3:0];
    if (byte_count == 16'd23) ip_protocol_next      = data_byte;
    if (byte_count == 16'd30) dest_addr_next[31:24] = data_byte;
    if (byte_count == 16'd31) dest_addr_next[23:16] = data_byte;
    if (byte_count == 16'd32) dest_addr_next[15:8]  = data_byte;
    if (byte_count == 16'd33) dest_addr_next[7:0]   = data_byte;
    if (byte_count > 16'd14) begin
      if (byte_count == {8'd0, l4_cur}) icmp_kind_next = data_byte;
      if (byte_count == {8'd0, l4_cur + 8'd2}) l4_dport_next[15:8] = data_byte;
      if (byte_count == {8'd0, l4_cur + 8'd3}) l4_dport_next[7:0]  = data_byte;
    end
  end

  // Verdict checks in priority order; the UDP port table search is left to
  // the cell row and flagged by lookup.
  always_comb begin
    len    = {1'b0, byte_count} + 17'd1;
    l4_dec = ETH_LEN + {2'b00, header_words_next, 2'b00};
    l4_len = {9'd0, l4_dec};
    lookup = 1'b0;
    if (len < {9'd0, ETH_LEN}) begin
      reason = REASON_TRUNCATED;
    end else if (ether_type_next != ETHERTYPE_IPV4) begin
      reason = REASON_NOT_IPV4;
    end else if (len < {9'd0, ETH_LEN} + IPV4_MIN_LEN) begin
      reason = REASON_TRUNCATED;
    end else if (header_words_next < IHL_MIN) begin
      reason = REASON_BAD_IHL;
    end else if (len < l4_len) begin
      reason = REASON_TRUNCATED;
    end else if (ip_protocol_next == PROTO_TCP) begin
      if (len < l4_len + TCP_HDR_LEN) begin
        reason = REASON_TRUNCATED;
      end else begin
        reason = (l4_dport_next == PORT_HTTPS) ? REASON_ALLOW : REASON_TCP_DENY;
      end
    end else if (ip_protocol_next == PROTO_UDP) begin
      if (len < l4_len + UDP_HDR_LEN) begin
        reason = REASON_TRUNCATED;
      end else if (l4_dport_next == PORT_DNS) begin
        reason = (resolver_enable && dest_addr_next == resolver_addr) ?
                 REASON_ALLOW : REASON_UDP_DENY;
      end else begin
        reason = REASON_UDP_DENY;
        lookup = 1'b1;
      end
    end else if (ip_protocol_next == PROTO_ICMP) begin
      if (len < l4_len + ICMP_HDR_LEN) begin
        reason = REASON_TRUNCATED;
      end else begin
        reason = (icmp_kind_next == ICMP_ECHO_REQ) ? REASON_ALLOW : REASON_ICMP_DENY;
      end
    end else if (ip_protocol_next == PROTO_IPV6) begin
      reason = REASON_IPV6_IN4;
    end else begin
      reason = REASON_OTHER;
    end
  end

  always_comb begin
    tok_next         = '0;
    tok_next.idx     = slot_index;
    tok_next.slot_on = slot_valid;
    tok_next.port    = (op == OP_SLOT_WRITE) ? slot_port : l4_dport_next;
    tok_next.reason  = reason;
    tok_next.lookup  = lookup;
    if (accept) begin
      tok_next.write = (op == OP_SLOT_WRITE);
      tok_next.query = (op == OP_PACKET_BYTE) && last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok          <= '0;
      byte_count   <= '0;
      ether_type   <= '0;
      header_words <= '0;
      ip_protocol  <= '0;
      dest_addr    <= '0;
      l4_dport     <= '0;
      icmp_kind    <= '0;
    end else begin
      if (adv) tok <= tok_next;
      if (accept && op == OP_PACKET_BYTE) begin
        if (last_byte) begin
          byte_count   <= '0;
          ether_type   <= '0;
          header_words <= '0;
          ip_protocol  <= '0;
          dest_addr    <= '0;
          l4_dport     <= '0;
          icmp_kind    <= '0;
        end else begin
          if (byte_count != 16'hFFFF) byte_count <= byte_count + 16'd1;
          ether_type   <= ether_type_next;
          header_words <= header_words_next;
          ip_protocol  <= ip_protocol_next;
          dest_addr    <= dest_addr_next;
          l4_dport     <= l4_dport_next;
          icmp_kind    <= icmp_kind_next;
        end
      end
    end
  end

endmodule

// ----- design/ipf_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_cell: one slot of the allowed UDP port table
// Holds one slot, applies write tokens addressed to it and marks passing
// verdict tokens whose port it holds.
// ----------------------------------------------------------------------------
module ipf_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [ipf_pkg::CELL_IDX_W-1:0] cell_index,
  input  ipf_pkg::ipf_tok_t             tok_in,
  output ipf_pkg::ipf_tok_t             tok_out
);
  import ipf_pkg::*;

  logic              slot_on;
  logic [PORT_W-1:0] slot_port;
  logic              addressed;
  logic              match;
  ipf_tok_t          tok_pass;

  assign addressed = tok_in.write && (32'(tok_in.idx) == 32'(cell_index));
  assign match     = tok_in.query && slot_on && (slot_port == tok_in.port);

  // The token moves on unchanged except for the hit mark.
  always_comb begin
    tok_pass     = tok_in;
    tok_pass.hit = tok_in.hit | match;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_on <= 1'b0;
      tok_out <= '0;
    end else if (adv) begin
      tok_out <= tok_pass;
      if (addressed) slot_on <= tok_in.slot_on;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && addressed) slot_port <= tok_in.port;
  end

endmodule

// ----- design/ipv4_port_filter_verdict.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_port_filter_verdict: byte-stream IPv4 layer-4 port filter
// Parses Ethernet/IPv4 frames one byte per item and returns an allow or drop
// verdict with a reason code for every frame, on its last byte.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: data_byte, slot_index, slot_port,
//                                   slot_valid; tuser: op; tlast: last_byte
// m_*       out  m_tvalid/m_tready  tdata: allow, verdict_reason
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// The block accepts one item per clock cycle while the row is not stalled. A
// frame's verdict travels from the parser's token register, which loads at the
// edge that accepts its last byte, through every port table cell in turn and
// then into the output register.
// Slot writes travel down the same row of cells as verdicts, so each verdict
// sees exactly the writes accepted before its last byte.
// Reset clears all slots and frame state; no sweep is needed.
// While reset is high, s_tready and cfg_ready are low.
// When a verdict reaches the end of the row while the output register is
// still full and not taken, the whole row holds and s_tready drops.
//
module ipv4_port_filter_verdict (
  input  logic                            clk,
  input  logic                            rst,
  // Input items.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,  // data_byte[7:0], slot_index[14:8],
                                                    // slot_port[30:15], slot_valid[31]
  input  logic                            s_tuser,  // op
  input  logic                            s_tlast,  // last_byte
  // Result items.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,  // allow[0], verdict_reason[4:1],
                                                    // zero fill[7:5]
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ipf_pkg::*;

  logic [ADDR_W-1:0]   resolver_addr;
  logic                resolver_enable;
  logic                adv;
  logic                accept;
  logic [REASON_W-1:0] final_reason;
  ipf_tok_t            chain [PORT_TABLE_DEPTH+1];
  ipf_tok_t            tail;

  // Configuration registers; writes are taken whenever reset is low.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolver_addr   <= '0;
      resolver_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RESOLVER_ADDR:   resolver_addr   <= cfg_data;
        CFG_RESOLVER_ENABLE: resolver_enable <= cfg_data[0];
      endcase
    end
  end

  // The row moves unless a verdict at its end has nowhere to go.
  assign tail     = chain[PORT_TABLE_DEPTH];
  assign adv      = !(tail.query && m_tvalid && !m_tready);
  assign s_tready = adv && !rst;
  assign accept   = s_tvalid && s_tready;

  ipf_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .accept          (accept),
    .op              (s_tuser),
    .data_byte       (s_tdata[7:0]),
    .last_byte       (s_tlast),
    .slot_index      (s_tdata[14:8]),
    .slot_port       (s_tdata[30:15]),
    .slot_valid      (s_tdata[31]),
    .resolver_addr   (resolver_addr),
    .resolver_enable (resolver_enable),
    .tok             (chain[0])
  );

  // One cell per port table slot, each handing its token to the next.
  for (genvar k = 0; k < PORT_TABLE_DEPTH; k++) begin : g_cell
    ipf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .cell_index (CELL_IDX_W'(k)),
      .tok_in     (chain[k]),
      .tok_out    (chain[k+1])
    );
  end

  // A UDP verdict that waited on the table resolves here.
  assign final_reason = tail.lookup ? (tail.hit ? REASON_ALLOW : REASON_UDP_DENY)
                                    : tail.reason;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && tail.query) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail.query) begin
      m_tdata <= {3'b000, final_reason, final_reason == REASON_ALLOW};
    end
  end

  // The row only stalls behind a full, untaken output register.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && tail.query))
    else $error("row stalled without a blocked verdict");

  // A blocked verdict stays at the end of the row.
  a_tail_hold : assert property (@(posedge clk) disable iff (rst)
    (tail.query && m_tvalid && !m_tready) |=> (tail.query && $stable(tail.reason)))
    else $error("blocked verdict left the row");

  // The allow bit agrees with the reason code.
  a_allow_code : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[4:1] == REASON_ALLOW)))
    else $error("allow bit disagrees with reason");

  // A token is never both a slot write and a verdict.
  a_tok_kind : assert property (@(posedge clk) disable iff (rst)
    !(chain[0].query && chain[0].write))
    else $error("token marked as write and verdict");

endmodule

// ----- sim/ipf_verdict_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_verdict_checker: scoreboard for the IPv4 port filter
// Watches the input, configuration and verdict channels, predicts each frame
// verdict from the bytes and slot writes it sees, and compares the verdicts.
// ----------------------------------------------------------------------------
module ipf_verdict_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [31:0]                     s_tdata,
  input  logic                            s_tuser,
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [7:0]                      m_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ipf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatch_count,
  output int                              verdicts_pending
);
  import ipf_pkg::*;

  typedef struct packed {
    logic                allow;
    logic [REASON_W-1:0] reason;
  } verdict_t;

  verdict_t expected_verdicts[$];
  int       fail_n = 0;

  // Frame state captured from the header bytes.
  logic [15:0] frame_bytes;
  logic [15:0] eth_type;
  logic [3:0]  ihl;
  logic [7:0]  proto;
  logic [31:0] dst_addr;
  logic [15:0] dst_port;
  logic [7:0]  icmp_type;

  logic              slot_on   [PORT_TABLE_DEPTH];
  logic [PORT_W-1:0] slot_value[PORT_TABLE_DEPTH];
  logic [ADDR_W-1:0] resolver;
  logic              resolver_on;

  assign mismatch_count = fail_n;

  function automatic void clear_frame();
    frame_bytes = '0;
    eth_type    = '0;
    ihl         = '0;
    proto       = '0;
    dst_addr    = '0;
    dst_port    = '0;
    icmp_type   = '0;
  endfunction

  function automatic bit port_in_table(logic [PORT_W-1:0] port);
    for (int i = 0; i < PORT_TABLE_DEPTH; i++) begin
      if (slot_on[i] && slot_value[i] == port) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void take_header_byte(int pos, logic [7:0] b);
    int l4;
    l4 = int'(ETH_LEN) + int'(ihl) * 4;
    if (pos == 12) eth_type[15:8] = b;
    if (pos == 13) eth_type[7:0] = b;
    if (pos == 14) ihl = b[3:0];
    if (pos == 23) proto = b;
    if (pos >= 30 && pos <= 33) dst_addr[(33 - pos) * 8 +: 8] = b;
    // The layer-4 offsets only mean something once IHL has been taken.
    if (pos > 14) begin
      if (pos == l4) icmp_type = b;
      if (pos == l4 + 2) dst_port[15:8] = b;
      if (pos == l4 + 3) dst_port[7:0] = b;
    end
  endfunction

  function automatic logic [REASON_W-1:0] predict_reason(int len);
    int l4;
    l4 = int'(ETH_LEN) + int'(ihl) * 4;
    if (len < int'(ETH_LEN)) return REASON_TRUNCATED;
    if (eth_type != ETHERTYPE_IPV4) return REASON_NOT_IPV4;
    if (len < int'(ETH_LEN) + int'(IPV4_MIN_LEN)) return REASON_TRUNCATED;
    if (ihl < IHL_MIN) return REASON_BAD_IHL;
    if (len < l4) return REASON_TRUNCATED;
    if (proto == PROTO_TCP) begin
      if (len < l4 + int'(TCP_HDR_LEN)) return REASON_TRUNCATED;
      return (dst_port == PORT_HTTPS) ? REASON_ALLOW : REASON_TCP_DENY;
    end
    if (proto == PROTO_UDP) begin
      if (len < l4 + int'(UDP_HDR_LEN)) return REASON_TRUNCATED;
      // Port 53 only passes through the resolver, never through the table.
      if (dst_port == PORT_DNS)
        return (resolver_on && dst_addr == resolver) ? REASON_ALLOW : REASON_UDP_DENY;
      return port_in_table(dst_port) ? REASON_ALLOW : REASON_UDP_DENY;
    end
    if (proto == PROTO_ICMP) begin
      if (len < l4 + int'(ICMP_HDR_LEN)) return REASON_TRUNCATED;
      return (icmp_type == ICMP_ECHO_REQ) ? REASON_ALLOW : REASON_ICMP_DENY;
    end
    if (proto == PROTO_IPV6) return REASON_IPV6_IN4;
    return REASON_OTHER;
  endfunction

  always @(posedge clk) begin
    int                  len;
    int                  idx;
    logic [REASON_W-1:0] r;
    verdict_t            exp_v;
    if (rst) begin
      clear_frame();
      for (int i = 0; i < PORT_TABLE_DEPTH; i++) begin
        slot_on[i]    = 1'b0;
        slot_value[i] = '0;
      end
      resolver    = '0;
      resolver_on = 1'b0;
      expected_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RESOLVER_ADDR:   resolver = cfg_data;
          CFG_RESOLVER_ENABLE: resolver_on = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_SLOT_WRITE) begin
          idx = int'(s_tdata[14:8]);
          if (idx < PORT_TABLE_DEPTH) begin
            slot_on[idx]    = s_tdata[31];
            slot_value[idx] = s_tdata[31] ? s_tdata[30:15] : '0;
          end
        end else begin
          take_header_byte(int'(frame_bytes), s_tdata[7:0]);
          len = int'(frame_bytes) + 1;
          if (frame_bytes != 16'hFFFF) frame_bytes = frame_bytes + 16'd1;
          if (s_tlast) begin
            r = predict_reason(len);
            exp_v.allow  = (r == REASON_ALLOW);
            exp_v.reason = r;
            expected_verdicts.push_back(exp_v);
            clear_frame();
          end
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected verdict item, m_tdata=%02h", m_tdata);
          fail_n++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (m_tdata[0] !== exp_v.allow) begin
            $error("allow: expected %0d, actual %0d", exp_v.allow, m_tdata[0]);
            fail_n++;
          end
          if (m_tdata[4:1] !== exp_v.reason) begin
            $error("verdict_reason: expected %0d, actual %0d", exp_v.reason, m_tdata[4:1]);
            fail_n++;
          end
        end
      end
    end
    verdicts_pending <= expected_verdicts.size();
  end

endmodule

// ----- sim/tb_ipv4_port_filter_verdict.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_port_filter_verdict: stimulus and verdict for the IPv4 port filter
// Feeds directed and random Ethernet frames with interleaved port table
// writes, across several resolver settings, while a checker module predicts
// and compares every frame verdict.
// ----------------------------------------------------------------------------
module tb_ipv4_port_filter_verdict;
  import ipf_pkg::*;

  // A verdict passes the cell row and the output register after the last byte of
  // its frame; slot writes walk down the same cell row.
  localparam int VERDICT_LATENCY  = PORT_TABLE_DEPTH + 1;
  // Long enough for several verdicts to pile up behind a blocked output, so
  // the row stalls and the block drops s_tready.
  localparam int SINK_HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS      = 20;
  localparam int PHASE_FRAMES     = 1;
  localparam int NUM_PHASES       = 4;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [31:0]            s_tdata   = '0;
  logic                   s_tuser   = OP_PACKET_BYTE;
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [7:0]             m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_RESOLVER_ADDR;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int mismatch_count;
  int verdicts_pending;

  // Idling controls shared between the stimulus and the sink.
  bit src_idle   = 1'b1;
  bit sink_idle  = 1'b1;
  bit sink_hold  = 1'b0;
  bit mid_writes = 1'b0;

  // What the stimulus knows of the table and the resolver, used only to aim
  // frames at interesting ports and addresses.
  logic [PORT_W-1:0] shadow_port[PORT_TABLE_DEPTH];
  int                written_slots[$];
  logic [ADDR_W-1:0] cur_resolver = '0;

  logic [7:0] frame_q[$];
  int         phase_items;
  int         phase_frames;

  ipv4_port_filter_verdict i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ipf_verdict_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .verdicts_pending (verdicts_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #(2_000_000);
    $display("ipv4_port_filter_verdict test failed");
    $finish;
  end

  // Verdict sink. It takes items freely, idles in short random bursts, and
  // once on request holds off for a long stretch counted here.
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        m_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
        m_tready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offers one input item and returns at the edge where it is accepted.
  // tvalid is left high so that a following item goes out back to back.
  task automatic send_item(input logic op, input logic [7:0] b, input logic last,
                           input logic [SLOT_IDX_W-1:0] idx,
                           input logic [PORT_W-1:0] port, input logic on);
    if (src_idle && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tlast  <= last;
    s_tdata  <= {on, port, idx, b};
    do @(posedge clk); while (!s_tready);
    phase_items++;
  endtask

  // A slot write carries junk in the byte and last fields, which the block
  // must ignore.
  task automatic write_slot(input logic [SLOT_IDX_W-1:0] idx,
                            input logic [PORT_W-1:0] port, input logic on);
    send_item(OP_SLOT_WRITE, 8'($urandom), 1'($urandom), idx, port, on);
    shadow_port[idx] = port;
    written_slots.push_back(int'(idx));
  endtask

  task automatic random_slot_write();
    logic [PORT_W-1:0] port;
    port = ($urandom_range(0, 7) == 0) ? PORT_DNS : PORT_W'($urandom);
    write_slot(SLOT_IDX_W'($urandom), port, $urandom_range(0, 7) != 0);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (index == CFG_RESOLVER_ADDR) cur_resolver = value;
  endtask

  // Stops offering, waits for every verdict, then lets any slot write still
  // walking down the cell row drain out.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (verdicts_pending != 0);
    repeat (VERDICT_LATENCY + 8) @(posedge clk);
  endtask

  function automatic void put_byte(int pos, logic [7:0] b);
    if (pos < frame_q.size()) frame_q[pos] = b;
  endfunction

  // Builds a frame of len bytes with the given header fields (random filler
  // elsewhere, fields past the end cut off) and sends it. kind is the first
  // layer-4 byte: the ICMP type, or the high byte of the source port.
  task automatic send_frame(input logic [15:0] etype, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [31:0] daddr,
                            input logic [15:0] dport, input logic [7:0] kind,
                            input int len);
    int l4;
    frame_q.delete();
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom));
    l4 = 14 + int'(ihl) * 4;
    put_byte(12, etype[15:8]);
    put_byte(13, etype[7:0]);
    put_byte(14, {4'h4, ihl});
    put_byte(23, proto);
    for (int i = 0; i < 4; i++) put_byte(30 + i, daddr[(3 - i) * 8 +: 8]);
    put_byte(l4, kind);
    put_byte(l4 + 2, dport[15:8]);
    put_byte(l4 + 3, dport[7:0]);
    for (int i = 0; i < len; i++) begin
      // Table writes landing inside a frame must leave its parse untouched.
      if (mid_writes && $urandom_range(0, 15) == 0) random_slot_write();
      send_item(OP_PACKET_BYTE, frame_q[i], i == len - 1, SLOT_IDX_W'($urandom),
                PORT_W'($urandom), 1'($urandom));
    end
    phase_frames++;
  endtask

  // One random frame. Most are well formed with random content so that the
  // protocol checks are reached; the rest are noise or cut short.
  task automatic random_frame();
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] daddr;
    logic [15:0] dport;
    logic [7:0]  kind;
    int          full;
    int          len;
    int          pick;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) random_slot_write();
    mid_writes = ($urandom_range(0, 9) == 0);
    etype = ETHERTYPE_IPV4;
    ihl   = IHL_MIN;
    daddr = $urandom;
    dport = 16'($urandom);
    kind  = 8'($urandom);
    pick  = $urandom_range(0, 99);
    if (pick < 12) begin
      if ($urandom_range(0, 1) == 0) etype = 16'($urandom);
      ihl   = 4'($urandom);
      proto = 8'($urandom);
      len   = $urandom_range(1, 90);
    end else begin
      if ($urandom_range(0, 15) == 0) etype = 16'($urandom);
      case ($urandom_range(0, 7))
        0:       ihl = 4'($urandom_range(0, 4));
        1:       ihl = 4'($urandom_range(6, 15));
        default: ihl = IHL_MIN;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        proto = PROTO_TCP;
        if ($urandom_range(0, 1) == 0) dport = PORT_HTTPS;
      end else if (pick < 65) begin
        proto = PROTO_UDP;
        case ($urandom_range(0, 2))
          0: begin
            dport = PORT_DNS;
            if ($urandom_range(0, 1) == 0) daddr = cur_resolver;
          end
          1: begin
            if (written_slots.size() > 0)
              dport = shadow_port[written_slots[$urandom_range(0, written_slots.size() - 1)]];
          end
          default: ;
        endcase
      end else if (pick < 80) begin
        proto = PROTO_ICMP;
        if ($urandom_range(0, 1) == 0) kind = ICMP_ECHO_REQ;
      end else if (pick < 85) begin
        proto = PROTO_IPV6;
      end else begin
        proto = 8'($urandom);
      end
      full = 14 + int'(ihl) * 4;
      if (proto == PROTO_TCP) full += int'(TCP_HDR_LEN);
      else if (proto == PROTO_UDP || proto == PROTO_ICMP) full += int'(UDP_HDR_LEN);
      if (full < 34) full = 34;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, full - 1)
                                        : full + $urandom_range(0, 8);
    end
    send_frame(etype, ihl, proto, daddr, dport, kind, len);
    mid_writes = 1'b0;
  endtask

  initial begin
    logic [31:0] resolver_a;
    logic [31:0] phase_addr[NUM_PHASES];
    logic        phase_en  [NUM_PHASES];
    resolver_a = 32'hC0A8_0135;
    phase_addr = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom};
    phase_en   = '{1'b1, 1'b1, 1'b0, 1'b1};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the resolver is off, so DNS to address zero is denied.
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, 32'h0, PORT_DNS, 8'h00, 42);
    settle();
    write_reg(CFG_RESOLVER_ADDR, resolver_a);
    write_reg(CFG_RESOLVER_ENABLE, 32'h1);

    // The sink holds off while the directed frames go in, so verdicts pile
    // up behind the output and the block stalls its input.
    sink_hold = 1'b1;

    // Length checks in their order: Ethernet, ethertype, IPv4 minimum,
    // IHL, then the full IPv4 header and the layer-4 header.
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 32'h0, PORT_HTTPS, 8'h00, 1);
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 32'h0, PORT_HTTPS, 8'h00, 13);
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 32'h0, PORT_HTTPS, 8'h00, 14);
    send_frame(16'h86DD, IHL_MIN, PROTO_TCP, 32'h0, PORT_HTTPS, 8'h00, 14);
    send_frame(ETHERTYPE_IPV4, 4'd4, PROTO_TCP, 32'h0, PORT_HTTPS, 8'h00, 33);
    send_frame(ETHERTYPE_IPV4, 4'd4, PROTO_TCP, 32'h0, PORT_HTTPS, 8'h00, 34);
    send_frame(ETHERTYPE_IPV4, 4'd6, PROTO_IPV6, 32'h0, 16'h0000, 8'h00, 37);
    send_frame(ETHERTYPE_IPV4, 4'hF, PROTO_TCP, 32'h0, PORT_HTTPS, 8'h00, 94);
    // TCP exactly at and one below the header end, then a wrong port.
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 32'h0, PORT_HTTPS, 8'h00, 54);
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 32'h0, PORT_HTTPS, 8'h00, 53);
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 32'h0, 16'hFFFF, 8'h00, 54);
    // DNS through the resolver, a short one, and one to another address,
    // also after port 53 has gone into the table.
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, resolver_a, PORT_DNS, 8'h00, 42);
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, resolver_a, PORT_DNS, 8'h00, 41);
    write_slot(7'h7F, PORT_DNS, 1'b1);
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, ~resolver_a, PORT_DNS, 8'h00, 42);
    // Table port: absent, added, removed again.
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, 32'h0, 16'hFFFF, 8'h00, 42);
    write_slot(7'h00, 16'hFFFF, 1'b1);
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, 32'h0, 16'hFFFF, 8'h00, 42);
    write_slot(7'h00, 16'hFFFF, 1'b0);
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, 32'h0, 16'hFFFF, 8'h00, 42);
    // ICMP echo request and a short one.
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_ICMP, 32'h0, 16'h0000, ICMP_ECHO_REQ, 42);
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_ICMP, 32'h0, 16'h0000, ICMP_ECHO_REQ, 41);
    // Protocols with no layer-4 length check.
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_IPV6, 32'h0, 16'h0000, 8'h00, 34);
    send_frame(ETHERTYPE_IPV4, IHL_MIN, 8'hFF, 32'h0, 16'h0000, 8'h00, 34);
    // Slot writes in the middle of a frame.
    mid_writes = 1'b1;
    send_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, 32'h0, 16'h1234, 8'h00, 42);
    mid_writes = 1'b0;

    // Random phases, each under its own resolver setting; the last one runs
    // with no idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(CFG_RESOLVER_ADDR, phase_addr[p]);
      write_reg(CFG_RESOLVER_ENABLE, {31'b0, phase_en[p]});
      if (p == NUM_PHASES - 1) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end
      phase_items  = 0;
      phase_frames = 0;
      while (phase_items < PHASE_ITEMS || phase_frames < PHASE_FRAMES) random_frame();
    end

    settle();
    if (mismatch_count == 0) begin
      $display("ipv4_port_filter_verdict test passed");
    end else begin
      $display("ipv4_port_filter_verdict test failed");
    end
    $finish;
  end

endmodule

// ----- ipv4_port_filter_verdict.f -----
design/ipf_pkg.sv
design/ipf_parser.sv
design/ipf_cell.sv
design/ipv4_port_filter_verdict.sv
sim/ipf_verdict_checker.sv
sim/tb_ipv4_port_filter_verdict.sv
